// ----- rtl/dtpg_pkg.sv -----
// Package with the shared constants, types and helper functions of the test pattern generator.
package dtpg_pkg;

  localparam int COORD_BITS = 11;
  localparam int DIM_BITS   = 11;
  localparam int CELL_BITS  = 8;
  localparam int PAT_BITS   = 3;
  localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int NUM_BITS   = COORD_BITS + 9;
  localparam int DEN_BITS   = ((DIM_BITS > CELL_BITS) ? DIM_BITS : CELL_BITS) + 1;
  localparam int DIV_CNT_BITS = $clog2(NUM_BITS);
  localparam int PIX_BITS   = 16;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [PAT_BITS-1:0] PAT_RED     = 3'd0;
  localparam logic [PAT_BITS-1:0] PAT_GREEN   = 3'd1;
  localparam logic [PAT_BITS-1:0] PAT_BLUE    = 3'd2;
  localparam logic [PAT_BITS-1:0] PAT_WHITE   = 3'd3;
  localparam logic [PAT_BITS-1:0] PAT_GRAD    = 3'd4;
  localparam logic [PAT_BITS-1:0] PAT_CHECKER = 3'd5;

  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_CELL    = 2'd3;

  localparam logic [PAT_BITS-1:0]  RST_PATTERN = 3'd0;
  localparam logic [DIM_BITS-1:0]  RST_WIDTH   = 11'd800;
  localparam logic [DIM_BITS-1:0]  RST_HEIGHT  = 11'd1280;
  localparam logic [CELL_BITS-1:0] RST_CELL    = 8'd50;

  localparam logic [7:0] CH_FULL  = 8'hFF;
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] MASK_RB  = 8'hF8;
  localparam logic [7:0] MASK_G   = 8'hFC;

  typedef struct packed {
    logic [PAT_BITS-1:0]  pattern;
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
    logic [CELL_BITS-1:0] cell_size;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic out_free;
  } sts_t;

  function automatic logic [PIX_BITS-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
    logic [7:0] rm;
    logic [7:0] gm;
    rm = r & MASK_RB;
    gm = g & MASK_G;
    return {rm[7:3], gm[7:2], b[7:3]};
  endfunction

endpackage

// ----- rtl/dtpg_if.sv -----
// Stream channel interfaces for the tick input and the pixel result of the pattern generator.
interface dtpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

interface dtpg_out_if;
  logic                            valid;
  logic                            ready;
  logic [dtpg_pkg::PIX_BITS-1:0]   pixel;
  logic [dtpg_pkg::COORD_BITS-1:0] column;
  logic [dtpg_pkg::COORD_BITS-1:0] row;
  logic                            line_end;
  logic                            frame_end;

  modport source(output valid, output pixel, output column, output row, output line_end,
                 output frame_end, input ready);
  modport sink(input valid, input pixel, input column, input row, input line_end,
               input frame_end, output ready);
endinterface

// ----- rtl/dtpg_regs.sv -----
// APB configuration registers of the pattern generator.
module dtpg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtpg_pkg::APB_AW-1:0]   paddr,
  input  logic [dtpg_pkg::APB_DW-1:0]   pwdata,
  output logic [dtpg_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output dtpg_pkg::cfg_t                cfg
);

  dtpg_pkg::cfg_t cfg_r;
  dtpg_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        dtpg_pkg::REG_PATTERN: cfg_nxt.pattern   = pwdata[dtpg_pkg::PAT_BITS-1:0];
        dtpg_pkg::REG_WIDTH:   cfg_nxt.width     = pwdata[dtpg_pkg::DIM_BITS-1:0];
        dtpg_pkg::REG_HEIGHT:  cfg_nxt.height    = pwdata[dtpg_pkg::DIM_BITS-1:0];
        dtpg_pkg::REG_CELL:    cfg_nxt.cell_size = pwdata[dtpg_pkg::CELL_BITS-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dtpg_pkg::REG_PATTERN: prdata = dtpg_pkg::APB_DW'(cfg_r.pattern);
      dtpg_pkg::REG_WIDTH:   prdata = dtpg_pkg::APB_DW'(cfg_r.width);
      dtpg_pkg::REG_HEIGHT:  prdata = dtpg_pkg::APB_DW'(cfg_r.height);
      dtpg_pkg::REG_CELL:    prdata = dtpg_pkg::APB_DW'(cfg_r.cell_size);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern   <= dtpg_pkg::RST_PATTERN;
      cfg_r.width     <= dtpg_pkg::RST_WIDTH;
      cfg_r.height    <= dtpg_pkg::RST_HEIGHT;
      cfg_r.cell_size <= dtpg_pkg::RST_CELL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/dtpg_div.sv -----
// Bit-serial restoring divider that produces one quotient bit per step.
module dtpg_div (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [dtpg_pkg::NUM_BITS-1:0] num,
  input  logic [dtpg_pkg::DEN_BITS-1:0] den,
  output logic [dtpg_pkg::NUM_BITS-1:0] quot
);

  logic [dtpg_pkg::NUM_BITS-1:0] quot_r;
  logic [dtpg_pkg::NUM_BITS-1:0] quot_nxt;
  logic [dtpg_pkg::DEN_BITS-1:0] rem_r;
  logic [dtpg_pkg::DEN_BITS-1:0] rem_nxt;
  logic [dtpg_pkg::DEN_BITS:0]   trial;
  logic [dtpg_pkg::DEN_BITS:0]   den_ext;
  logic [dtpg_pkg::DEN_BITS:0]   diff;

  assign trial   = {rem_r, quot_r[dtpg_pkg::NUM_BITS-1]};
  assign den_ext = {1'b0, den};
  assign diff    = trial - den_ext;
  assign quot    = quot_r;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      quot_nxt = num;
      rem_nxt  = '0;
    end else if (step) begin
      if (trial >= den_ext) begin
        rem_nxt  = diff[dtpg_pkg::DEN_BITS-1:0];
        quot_nxt = {quot_r[dtpg_pkg::NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[dtpg_pkg::DEN_BITS-1:0];
        quot_nxt = {quot_r[dtpg_pkg::NUM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

// ----- rtl/dtpg_ctrl.sv -----
// Controller state machine that sequences accept, division steps and result loading.
module dtpg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtpg_pkg::sts_t      sts,
  output dtpg_pkg::cmd_t      cmd
);

  dtpg_pkg::state_t                  state_r;
  dtpg_pkg::state_t                  state_nxt;
  logic [dtpg_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic [dtpg_pkg::DIV_CNT_BITS-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtpg_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      dtpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = sts.needs_div ? dtpg_pkg::ST_DIV : dtpg_pkg::ST_OUT;
        end
      end
      dtpg_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == dtpg_pkg::DIV_CNT_BITS'(dtpg_pkg::NUM_BITS - 1)) begin
          state_nxt = dtpg_pkg::ST_OUT;
        end
      end
      dtpg_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = dtpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtpg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/dtpg_datapath.sv -----
// Datapath with raster counters, pattern dividers, color selection and the result register.
module dtpg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dtpg_pkg::cfg_t                  cfg,
  input  dtpg_pkg::cmd_t                  cmd,
  output dtpg_pkg::sts_t                  sts,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtpg_pkg::PIX_BITS-1:0]   out_pixel,
  output logic [dtpg_pkg::COORD_BITS-1:0] out_column,
  output logic [dtpg_pkg::COORD_BITS-1:0] out_row,
  output logic                            out_line_end,
  output logic                            out_frame_end
);

  localparam int CB = dtpg_pkg::COORD_BITS;
  localparam int NB = dtpg_pkg::NUM_BITS;
  localparam int DB = dtpg_pkg::DEN_BITS;

  logic [CB-1:0] col_r;
  logic [CB-1:0] col_nxt;
  logic [CB-1:0] row_r;
  logic [CB-1:0] row_nxt;
  logic [CB-1:0] x_eff;
  logic [CB-1:0] y_eff;

  logic                    valid_r;
  logic [dtpg_pkg::PIX_BITS-1:0] pixel_r;
  logic [CB-1:0]           column_r;
  logic [CB-1:0]           rowo_r;
  logic                    lend_r;
  logic                    fend_r;

  logic [dtpg_pkg::DIM_BITS-1:0]  w;
  logic [dtpg_pkg::DIM_BITS-1:0]  h;
  logic [dtpg_pkg::CELL_BITS-1:0] c;
  logic [dtpg_pkg::CMP_BITS-1:0]  x_cmp;
  logic [dtpg_pkg::CMP_BITS-1:0]  y_cmp;
  logic [dtpg_pkg::CMP_BITS-1:0]  wm1;
  logic [dtpg_pkg::CMP_BITS-1:0]  hm1;
  logic                           lend;
  logic                           fend;

  logic [NB-1:0] xn;
  logic [NB-1:0] yn;
  logic [NB-1:0] sn;
  logic [NB-1:0] num_a;
  logic [NB-1:0] num_b;
  logic [NB-1:0] num_c;
  logic [DB-1:0] den_a;
  logic [DB-1:0] den_b;
  logic [DB-1:0] den_c;
  logic [NB-1:0] q_a;
  logic [NB-1:0] q_b;
  logic [NB-1:0] q_c;
  logic [dtpg_pkg::PIX_BITS-1:0] color;
  logic          is_grad;

  assign w = (cfg.width  == '0) ? dtpg_pkg::DIM_BITS'(1) : cfg.width;
  assign h = (cfg.height == '0) ? dtpg_pkg::DIM_BITS'(1) : cfg.height;
  assign c = (cfg.cell_size == '0) ? dtpg_pkg::CELL_BITS'(1) : cfg.cell_size;

  assign x_eff = in_restart ? '0 : col_r;
  assign y_eff = in_restart ? '0 : row_r;

  assign is_grad = (cfg.pattern == dtpg_pkg::PAT_GRAD);
  assign xn    = NB'(x_eff);
  assign yn    = NB'(y_eff);
  assign sn    = xn + yn;
  assign num_a = is_grad ? ((xn << 8) - xn) : xn;
  assign num_b = is_grad ? ((yn << 8) - yn) : yn;
  assign num_c = (sn << 8) - sn;
  assign den_a = is_grad ? DB'(w) : DB'(c);
  assign den_b = is_grad ? DB'(h) : DB'(c);
  assign den_c = DB'(w) + DB'(h);

  dtpg_div u_div_a (
    .clk(clk), .start(cmd.accept), .step(cmd.div_step), .num(num_a), .den(den_a), .quot(q_a)
  );
  dtpg_div u_div_b (
    .clk(clk), .start(cmd.accept), .step(cmd.div_step), .num(num_b), .den(den_b), .quot(q_b)
  );
  dtpg_div u_div_c (
    .clk(clk), .start(cmd.accept), .step(cmd.div_step), .num(num_c), .den(den_c), .quot(q_c)
  );

  assign x_cmp = dtpg_pkg::CMP_BITS'(col_r);
  assign y_cmp = dtpg_pkg::CMP_BITS'(row_r);
  assign wm1   = dtpg_pkg::CMP_BITS'(w - 1'b1);
  assign hm1   = dtpg_pkg::CMP_BITS'(h - 1'b1);
  assign lend  = (x_cmp >= wm1);
  assign fend  = lend && (y_cmp >= hm1);

  always_comb begin
    case (cfg.pattern)
      dtpg_pkg::PAT_RED:
        color = dtpg_pkg::pack565(dtpg_pkg::CH_FULL, dtpg_pkg::CH_NONE, dtpg_pkg::CH_NONE);
      dtpg_pkg::PAT_GREEN:
        color = dtpg_pkg::pack565(dtpg_pkg::CH_NONE, dtpg_pkg::CH_FULL, dtpg_pkg::CH_NONE);
      dtpg_pkg::PAT_BLUE:
        color = dtpg_pkg::pack565(dtpg_pkg::CH_NONE, dtpg_pkg::CH_NONE, dtpg_pkg::CH_FULL);
      dtpg_pkg::PAT_WHITE:
        color = dtpg_pkg::pack565(dtpg_pkg::CH_FULL, dtpg_pkg::CH_FULL, dtpg_pkg::CH_FULL);
      dtpg_pkg::PAT_GRAD:
        color = dtpg_pkg::pack565(q_a[7:0], q_b[7:0], q_c[7:0]);
      dtpg_pkg::PAT_CHECKER:
        color = (q_a[0] ^ q_b[0]) ?
                dtpg_pkg::pack565(dtpg_pkg::CH_FULL, dtpg_pkg::CH_FULL, dtpg_pkg::CH_FULL) :
                dtpg_pkg::pack565(dtpg_pkg::CH_NONE, dtpg_pkg::CH_NONE, dtpg_pkg::CH_NONE);
      default:
        color = '0;
    endcase
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      col_nxt = x_eff;
      row_nxt = y_eff;
    end else if (cmd.load_out) begin
      if (fend) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (lend) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign sts.needs_div = is_grad || (cfg.pattern == dtpg_pkg::PAT_CHECKER);
  assign sts.out_free  = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.load_out) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_r  <= color;
      column_r <= col_r;
      rowo_r   <= row_r;
      lend_r   <= lend;
      fend_r   <= fend;
    end
  end

  assign out_valid     = valid_r;
  assign out_pixel     = pixel_r;
  assign out_column    = column_r;
  assign out_row       = rowo_r;
  assign out_line_end  = lend_r;
  assign out_frame_end = fend_r;

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!valid_r || out_ready))
    else $error("Result loaded while the output register still holds an untaken request.");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> valid_r)
    else $error("Output valid did not follow a result load.");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && fend) |=> (col_r == '0 && row_r == '0))
    else $error("Raster counters did not wrap after the last pixel of a frame.");

  a_fend_has_lend: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && fend_r) |-> lend_r)
    else $error("Frame end flagged on a pixel that does not end its line.");

endmodule

// ----- rtl/display_test_pattern_generator.sv -----
// Top level of the display test pattern generator.
// Each request on the input channel (in_ch) is one pixel tick; its restart bit
// returns the raster to column 0, row 0 before the pixel is produced. The result
// channel (out_ch) carries one RGB565 pixel per tick with its column, row and
// line and frame end flags, in row-major order over the configured frame.
// Solid patterns go from accepting the tick straight to loading the result
// register. Gradient and checkerboard first run three bit-serial dividers
// that retire one quotient bit of a 20-bit numerator each cycle; out_ch.valid
// is then registered from the result load.
// A new tick is taken as soon as the previous result has been loaded, even if
// that result still waits in the output register; a stalled receiver holds the
// result and, once the next pixel is ready, stops further ticks.
// The APB port (cfg_) writes pattern select, width, height and checker cell at
// byte addresses 0, 4, 8 and 12; configure only while the generator is idle.
// Synchronous reset clears the counters, empties the output register and loads
// the register defaults: red, 800 by 1280 pixels, 50-pixel checker cells.
module display_test_pattern_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  dtpg_in_if.sink                       in_ch,
  dtpg_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dtpg_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [dtpg_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [dtpg_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  dtpg_pkg::cfg_t cfg;
  dtpg_pkg::cmd_t cmd;
  dtpg_pkg::sts_t sts;
  logic           in_ready;

  dtpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dtpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  dtpg_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_restart    (in_ch.restart),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_pixel     (out_ch.pixel),
    .out_column    (out_ch.column),
    .out_row       (out_ch.row),
    .out_line_end  (out_ch.line_end),
    .out_frame_end (out_ch.frame_end)
  );

endmodule
